FILE: src/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

    localparam int DEF_ROWS = 25;
    localparam int DEF_COLS = 80;

    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam logic [7:0] REVERSE_MASK = 8'h80;

    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_FF = 8'd12;
    localparam logic [7:0] CH_CR = 8'd13;

    typedef enum logic [2:0] {
        CMD_PUT     = 3'd0,
        CMD_GOTO    = 3'd1,
        CMD_ERASE_S = 3'd2,
        CMD_ERASE_L = 3'd3,
        CMD_SCR_UP  = 3'd4,
        CMD_SCR_DN  = 3'd5,
        CMD_READ    = 3'd6,
        CMD_NOP     = 3'd7
    } tcw_cmd_t;

    typedef enum logic [1:0] {
        ERASE_TO_END   = 2'd0,
        ERASE_FROM_BEG = 2'd1,
        ERASE_ALL      = 2'd2,
        ERASE_NONE     = 2'd3
    } tcw_erase_t;

    typedef enum logic [2:0] {
        CFG_EIGHTY  = 3'd0,
        CFG_COLOR   = 3'd1,
        CFG_REVERSE = 3'd2,
        CFG_SCROLL  = 3'd3,
        CFG_TOP     = 3'd4,
        CFG_BOTTOM  = 3'd5,
        CFG_LEFT    = 3'd6,
        CFG_RIGHT   = 3'd7
    } tcw_cfg_t;

endpackage
`default_nettype wire

FILE: src/tcw_geometry.sv
`default_nettype none
module tcw_geometry
    import tcw_pkg::*;
#(
    parameter int SCREEN_ROWS = DEF_ROWS,
    parameter int WIDE_COLS = DEF_COLS,
    localparam int CW = $clog2(WIDE_COLS),
    localparam int RW = $clog2(SCREEN_ROWS),
    localparam int AW = $clog2(SCREEN_ROWS * WIDE_COLS)
) (
    input  wire logic          eighty,
    input  wire logic [4:0]    mtop,
    input  wire logic [4:0]    mbot,
    input  wire logic [6:0]    mleft,
    input  wire logic [6:0]    mright,
    output logic      [CW:0]   cols,
    output logic      [CW-1:0] maxcol,
    output logic      [RW-1:0] top,
    output logic      [RW-1:0] bot,
    output logic      [CW-1:0] left,
    output logic      [CW-1:0] right,
    output logic      [AW-1:0] last_cell
);

    logic [7:0] maxcol8, maxrow8, rc8, bc8;

    always_comb begin
        cols = eighty ? (CW+1)'(WIDE_COLS) : (CW+1)'(WIDE_COLS / 2);
        maxcol = CW'(cols - 1'b1);
        last_cell = eighty ? AW'(SCREEN_ROWS * WIDE_COLS - 1)
                           : AW'(SCREEN_ROWS * (WIDE_COLS / 2) - 1);
        maxcol8 = 8'(maxcol);
        maxrow8 = 8'(SCREEN_ROWS - 1);
        rc8 = (8'(mright) > maxcol8) ? maxcol8 : 8'(mright);
        bc8 = (8'(mbot) > maxrow8) ? maxrow8 : 8'(mbot);
        // A range of a single cell or an inverted range falls back to the whole axis.
        if (8'(mleft) >= rc8) begin
            left = '0;
            right = maxcol;
        end else begin
            left = CW'(mleft);
            right = CW'(rc8);
        end
        if (8'(mtop) >= bc8) begin
            top = '0;
            bot = RW'(maxrow8);
        end else begin
            top = RW'(mtop);
            bot = RW'(bc8);
        end
    end

endmodule
`default_nettype wire

FILE: src/tcw_cell_store.sv
`default_nettype none
module tcw_cell_store
    import tcw_pkg::*;
#(
    parameter int DEPTH = DEF_ROWS * DEF_COLS,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] wa,
    input  wire logic [7:0]    wch,
    input  wire logic          wce,
    input  wire logic [7:0]    wco,
    input  wire logic [AW-1:0] ra,
    output logic      [7:0]    rch,
    output logic      [7:0]    rco
);

    logic [7:0] ch_mem [DEPTH];
    logic [7:0] co_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            ch_mem[wa] <= wch;
        end
        if (we && wce) begin
            co_mem[wa] <= wco;
        end
        rch <= ch_mem[ra];
        rco <= co_mem[ra];
    end

endmodule
`default_nettype wire

FILE: src/text_console_cell_writer.sv
// Goto, CR, LF (without a scroll) and no-op go from the plan state straight to the result;
// read, printables and most BS pass a read or put state first. Scroll copies the margin rows,
// then blanks one margin row; erase blanks its cells. The single write port of the cell store
// writes one cell per cycle. One command at a time: the next beat is taken in the cycle after
// m_tvalid rises, and a result still waiting holds back the next one. Reset: aresetn clears
// every cell, one per cycle, before the first input beat is taken.
`default_nettype none
module text_console_cell_writer
    import tcw_pkg::*;
#(
    parameter int SCREEN_ROWS = DEF_ROWS,
    parameter int WIDE_COLS = DEF_COLS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cmd[2:0], ch[10:3], col[18:11], row[26:19], mode[28:27], cell_color[36:29]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cursor_col[6:0], cursor_row[11:7], wrap_pending[12], read_char[20:13],
    // read_color[28:21]
    output logic      [31:0] m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [6:0]  cfg_data
);

    localparam int CW = $clog2(WIDE_COLS);
    localparam int RW = $clog2(SCREEN_ROWS);
    localparam int CELLS = SCREEN_ROWS * WIDE_COLS;
    localparam int AW = $clog2(CELLS);
    localparam logic [7:0] MAXROW8 = 8'(SCREEN_ROWS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_PLAN, ST_READ, ST_PUT, ST_COPY, ST_DRAIN,
        ST_RFILL, ST_LFILL, ST_FIN
    } state_t;

    state_t state_reg, ret_reg;

    logic eighty_reg, color_en_reg, reverse_reg, scroll_en_reg;
    logic [4:0] mtop_reg, mbot_reg;
    logic [6:0] mleft_reg, mright_reg;

    tcw_cmd_t cmd_reg;
    logic [7:0] ch_reg, col_in_reg, row_in_reg, color_reg;
    tcw_erase_t mode_reg;

    logic [CW-1:0] cur_col_reg, put_col_reg, wx_reg, fx_reg;
    logic [RW-1:0] cur_row_reg, put_row_reg, sy_reg, sy_end_reg, fy_reg, fy_end_reg;
    logic wrap_reg, post_scroll_reg, up_reg, cp_valid_reg;
    logic [7:0] put_ch_reg, rd_ch_reg, rd_co_reg;
    logic [AW-1:0] clr_reg, fa_reg, fa_end_reg, cp_dst_reg;
    logic m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    logic [CW:0] cols;
    logic [CW-1:0] maxcol, g_left, g_right;
    logic [RW-1:0] g_top, g_bot;
    logic [AW-1:0] last_cell;

    tcw_geometry #(.SCREEN_ROWS(SCREEN_ROWS), .WIDE_COLS(WIDE_COLS)) u_geom (
        .eighty(eighty_reg), .mtop(mtop_reg), .mbot(mbot_reg),
        .mleft(mleft_reg), .mright(mright_reg), .cols(cols), .maxcol(maxcol),
        .top(g_top), .bot(g_bot), .left(g_left), .right(g_right),
        .last_cell(last_cell)
    );

    logic we, wce;
    logic [AW-1:0] wa, addr;
    logic [7:0] wch, wco, rch, rco, rv_mask;

    tcw_cell_store #(.DEPTH(CELLS)) u_store (
        .aclk(aclk), .we(we), .wa(wa), .wch(wch), .wce(wce), .wco(wco),
        .ra(addr), .rch(rch), .rco(rco)
    );

    // Cursor after the column clamp, goto/read targets, and the put char plan.
    logic [CW-1:0] cc, tx, c1, sb_col;
    logic [RW-1:0] ty, r1, lfa_row, lfb_row, sb_row, ay;
    logic [CW-1:0] ax;
    logic lfa_over, lfb_over, pre_scroll, sb_under;

    always_comb begin
        cc = (8'(cur_col_reg) > 8'(maxcol)) ? maxcol : cur_col_reg;
        tx = col_in_reg[7] ? '0 : ((col_in_reg > 8'(maxcol)) ? maxcol : CW'(col_in_reg));
        ty = row_in_reg[7] ? '0 : ((row_in_reg > MAXROW8) ? RW'(MAXROW8) : RW'(row_in_reg));
        lfa_over = ({1'b0, cur_row_reg} + 1'b1) > {1'b0, g_bot};
        lfa_row = lfa_over ? g_bot : RW'(cur_row_reg + 1'b1);
        r1 = wrap_reg ? lfa_row : cur_row_reg;
        c1 = wrap_reg ? g_left : cc;
        pre_scroll = wrap_reg && lfa_over && scroll_en_reg;
        lfb_over = ({1'b0, r1} + 1'b1) > {1'b0, g_bot};
        lfb_row = lfb_over ? g_bot : RW'(r1 + 1'b1);
        sb_under = !wrap_reg && (cc != g_left) && (cc == '0);
        if (wrap_reg) begin
            sb_col = cc;
            sb_row = cur_row_reg;
        end else if (cc == g_left) begin
            if (cur_row_reg <= g_top) begin
                sb_col = g_left;
                sb_row = g_top;
            end else begin
                sb_col = g_right;
                sb_row = RW'(cur_row_reg - 1'b1);
            end
        end else begin
            sb_col = CW'(cc - 1'b1);
            sb_row = cur_row_reg;
        end
        case (state_reg)
            ST_PLAN: begin
                ay = (cmd_reg == CMD_READ) ? ty : cur_row_reg;
                ax = (cmd_reg == CMD_READ) ? tx : cc;
            end
            ST_PUT: begin
                ay = put_row_reg;
                ax = put_col_reg;
            end
            ST_COPY: begin
                ay = sy_reg;
                ax = wx_reg;
            end
            ST_RFILL: begin
                ay = fy_reg;
                ax = fx_reg;
            end
            default: begin
                ay = cur_row_reg;
                ax = cc;
            end
        endcase
        addr = AW'(AW'(ay) * AW'(cols) + AW'(ax));
    end

    always_comb begin
        rv_mask = reverse_reg ? REVERSE_MASK : 8'h00;
        we = 1'b0;
        wa = addr;
        wch = SPACE_CODE ^ rv_mask;
        wce = color_en_reg;
        wco = color_reg;
        if (state_reg == ST_CLEAR) begin
            we = 1'b1;
            wa = clr_reg;
            wch = SPACE_CODE;
            wce = 1'b1;
            wco = 8'h00;
        end else if (cp_valid_reg) begin
            we = 1'b1;
            wa = cp_dst_reg;
            wch = rch;
            wco = rco;
        end else if (state_reg == ST_RFILL) begin
            we = 1'b1;
        end else if (state_reg == ST_LFILL) begin
            we = 1'b1;
            wa = fa_reg;
        end else if (state_reg == ST_PUT) begin
            we = 1'b1;
            wch = put_ch_reg ^ rv_mask;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eighty_reg <= 1'b0;
            color_en_reg <= 1'b0;
            reverse_reg <= 1'b0;
            scroll_en_reg <= 1'b1;
            mtop_reg <= 5'd0;
            mbot_reg <= 5'd24;
            mleft_reg <= 7'd0;
            mright_reg <= 7'd39;
        end else if (cfg_valid) begin
            case (tcw_cfg_t'(cfg_addr))
                CFG_EIGHTY:  eighty_reg <= cfg_data[0];
                CFG_COLOR:   color_en_reg <= cfg_data[0];
                CFG_REVERSE: reverse_reg <= cfg_data[0];
                CFG_SCROLL:  scroll_en_reg <= cfg_data[0];
                CFG_TOP:     mtop_reg <= cfg_data[4:0];
                CFG_BOTTOM:  mbot_reg <= cfg_data[4:0];
                CFG_LEFT:    mleft_reg <= cfg_data;
                CFG_RIGHT:   mright_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ret_reg <= ST_FIN;
            clr_reg <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            wrap_reg <= 1'b0;
            cp_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cp_valid_reg <= (state_reg == ST_COPY);
            if (m_tvalid_reg && m_tready && state_reg != ST_FIN) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= AW'(clr_reg + 1'b1);
                    if (clr_reg == AW'(CELLS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg <= tcw_cmd_t'(s_tdata[2:0]);
                        ch_reg <= s_tdata[10:3];
                        col_in_reg <= s_tdata[18:11];
                        row_in_reg <= s_tdata[26:19];
                        mode_reg <= tcw_erase_t'(s_tdata[28:27]);
                        color_reg <= s_tdata[36:29];
                        state_reg <= ST_PLAN;
                    end
                end
                ST_PLAN: begin
                    cur_col_reg <= cc;
                    rd_ch_reg <= 8'h00;
                    rd_co_reg <= 8'h00;
                    state_reg <= ST_FIN;
                    case (cmd_reg)
                        CMD_PUT: begin
                            case (ch_reg)
                                CH_CR: begin
                                    cur_col_reg <= g_left;
                                    wrap_reg <= 1'b0;
                                end
                                CH_LF: begin
                                    cur_col_reg <= g_left;
                                    wrap_reg <= 1'b0;
                                    cur_row_reg <= lfa_row;
                                    if (lfa_over && scroll_en_reg) begin
                                        up_reg <= 1'b1;
                                        sy_reg <= RW'(g_top + 1'b1);
                                        sy_end_reg <= g_bot;
                                        fy_reg <= g_bot;
                                        fy_end_reg <= g_bot;
                                        wx_reg <= g_left;
                                        fx_reg <= g_left;
                                        ret_reg <= ST_FIN;
                                        state_reg <= ST_COPY;
                                    end
                                end
                                CH_BS: begin
                                    cur_col_reg <= sb_col;
                                    cur_row_reg <= sb_row;
                                    wrap_reg <= 1'b0;
                                    put_ch_reg <= SPACE_CODE;
                                    post_scroll_reg <= 1'b0;
                                    if (sb_under) begin
                                        // Stepping back from column zero inside a left margin
                                        // blanks the last cell of the row above, if any.
                                        put_col_reg <= maxcol;
                                        put_row_reg <= RW'(cur_row_reg - 1'b1);
                                        if (cur_row_reg != '0) begin
                                            state_reg <= ST_PUT;
                                        end
                                    end else begin
                                        put_col_reg <= sb_col;
                                        put_row_reg <= sb_row;
                                        state_reg <= ST_PUT;
                                    end
                                end
                                CH_FF: begin
                                    cur_col_reg <= g_left;
                                    cur_row_reg <= g_top;
                                    wrap_reg <= 1'b0;
                                    fy_reg <= g_top;
                                    fy_end_reg <= g_bot;
                                    fx_reg <= g_left;
                                    ret_reg <= ST_FIN;
                                    state_reg <= ST_RFILL;
                                end
                                default: begin
                                    put_col_reg <= c1;
                                    put_row_reg <= r1;
                                    put_ch_reg <= ch_reg;
                                    post_scroll_reg <= 1'b0;
                                    if (c1 == g_right) begin
                                        cur_col_reg <= c1;
                                        cur_row_reg <= r1;
                                        wrap_reg <= 1'b1;
                                    end else if (c1 > g_right) begin
                                        cur_col_reg <= g_left;
                                        cur_row_reg <= lfb_row;
                                        wrap_reg <= 1'b0;
                                        post_scroll_reg <= lfb_over && scroll_en_reg;
                                    end else begin
                                        cur_col_reg <= CW'(c1 + 1'b1);
                                        cur_row_reg <= r1;
                                        wrap_reg <= 1'b0;
                                    end
                                    if (pre_scroll) begin
                                        up_reg <= 1'b1;
                                        sy_reg <= RW'(g_top + 1'b1);
                                        sy_end_reg <= g_bot;
                                        fy_reg <= g_bot;
                                        fy_end_reg <= g_bot;
                                        wx_reg <= g_left;
                                        fx_reg <= g_left;
                                        ret_reg <= ST_PUT;
                                        state_reg <= ST_COPY;
                                    end else begin
                                        state_reg <= ST_PUT;
                                    end
                                end
                            endcase
                        end
                        CMD_GOTO: begin
                            cur_col_reg <= tx;
                            cur_row_reg <= ty;
                            wrap_reg <= 1'b0;
                        end
                        CMD_ERASE_S: begin
                            fa_end_reg <= last_cell;
                            fa_reg <= (mode_reg == ERASE_TO_END) ? addr : '0;
                            if (mode_reg == ERASE_FROM_BEG) begin
                                fa_end_reg <= addr;
                            end
                            if (mode_reg != ERASE_NONE) begin
                                state_reg <= ST_LFILL;
                            end
                        end
                        CMD_ERASE_L: begin
                            fa_reg <= (mode_reg == ERASE_TO_END) ? addr : AW'(addr - AW'(cc));
                            fa_end_reg <= AW'(addr - AW'(cc) + AW'(cols) - 1'b1);
                            if (mode_reg == ERASE_FROM_BEG) begin
                                fa_end_reg <= addr;
                            end
                            if (mode_reg != ERASE_NONE) begin
                                state_reg <= ST_LFILL;
                            end
                        end
                        CMD_SCR_UP: begin
                            up_reg <= 1'b1;
                            sy_reg <= RW'(g_top + 1'b1);
                            sy_end_reg <= g_bot;
                            fy_reg <= g_bot;
                            fy_end_reg <= g_bot;
                            wx_reg <= g_left;
                            fx_reg <= g_left;
                            ret_reg <= ST_FIN;
                            state_reg <= ST_COPY;
                        end
                        CMD_SCR_DN: begin
                            up_reg <= 1'b0;
                            sy_reg <= RW'(g_bot - 1'b1);
                            sy_end_reg <= g_top;
                            fy_reg <= g_top;
                            fy_end_reg <= g_top;
                            wx_reg <= g_left;
                            fx_reg <= g_left;
                            ret_reg <= ST_FIN;
                            state_reg <= ST_COPY;
                        end
                        CMD_READ: begin
                            state_reg <= ST_READ;
                        end
                        default: ;
                    endcase
                end
                ST_READ: begin
                    rd_ch_reg <= rch;
                    rd_co_reg <= rco;
                    state_reg <= ST_FIN;
                end
                ST_PUT: begin
                    if (post_scroll_reg) begin
                        up_reg <= 1'b1;
                        sy_reg <= RW'(g_top + 1'b1);
                        sy_end_reg <= g_bot;
                        fy_reg <= g_bot;
                        fy_end_reg <= g_bot;
                        wx_reg <= g_left;
                        fx_reg <= g_left;
                        ret_reg <= ST_FIN;
                        state_reg <= ST_COPY;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_COPY: begin
                    // The source cell is read now and written one row over next cycle.
                    cp_dst_reg <= up_reg ? AW'(addr - AW'(cols)) : AW'(addr + AW'(cols));
                    if (wx_reg == g_right) begin
                        wx_reg <= g_left;
                        if (sy_reg == sy_end_reg) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            sy_reg <= up_reg ? RW'(sy_reg + 1'b1) : RW'(sy_reg - 1'b1);
                        end
                    end else begin
                        wx_reg <= CW'(wx_reg + 1'b1);
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_RFILL;
                end
                ST_RFILL: begin
                    if (fx_reg == g_right) begin
                        fx_reg <= g_left;
                        if (fy_reg == fy_end_reg) begin
                            state_reg <= ret_reg;
                        end else begin
                            fy_reg <= RW'(fy_reg + 1'b1);
                        end
                    end else begin
                        fx_reg <= CW'(fx_reg + 1'b1);
                    end
                end
                ST_LFILL: begin
                    fa_reg <= AW'(fa_reg + 1'b1);
                    if (fa_reg == fa_end_reg) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= {3'b000, rd_co_reg, rd_ch_reg, wrap_reg,
                                        5'(cur_row_reg), 7'(cur_col_reg)};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a command is in progress");

    a_copy_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cp_valid_reg |-> $past(state_reg == ST_COPY))
        else $error("copy write without a preceding source read");

    a_cursor_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> (8'(cur_row_reg) <= MAXROW8))
        else $error("cursor outside the screen at result time");

endmodule
`default_nettype wire

FILE: verif/text_console_cell_writer_tb.sv
`timescale 1ns / 100ps
module text_console_cell_writer_tb;
    import tcw_pkg::*;

    localparam int ROWS = 25;
    localparam int WIDE = 80;
    localparam int CELLS = ROWS * WIDE;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic [7:0] rd_color;
        logic [7:0] rd_char;
        logic       wrap;
        logic [4:0] row;
        logic [6:0] col;
    } cursor_report_t;

    class screen_scoreboard;
        logic [7:0] chars [CELLS];
        logic [7:0] colors [CELLS];
        int cur_col, cur_row;
        bit wrap;
        bit eighty, color_on, reverse, scroll_on;
        int m_top, m_bot, m_left, m_right;
        int cols, top, bot, left, right;
        logic [7:0] pen_color;
        cursor_report_t report_q[$];
        int errors;

        function new();
            for (int i = 0; i < CELLS; i++) begin
                chars[i] = SPACE_CODE;
                colors[i] = 8'd0;
            end
            cur_col = 0; cur_row = 0; wrap = 0;
            eighty = 0; color_on = 0; reverse = 0; scroll_on = 1;
            m_top = 0; m_bot = 24; m_left = 0; m_right = 39;
            errors = 0;
        endfunction

        function void set_reg(tcw_cfg_t a, logic [6:0] v);
            case (a)
                CFG_EIGHTY:  eighty = v[0];
                CFG_COLOR:   color_on = v[0];
                CFG_REVERSE: reverse = v[0];
                CFG_SCROLL:  scroll_on = v[0];
                CFG_TOP:     m_top = int'(v[4:0]);
                CFG_BOTTOM:  m_bot = int'(v[4:0]);
                CFG_LEFT:    m_left = int'(v);
                CFG_RIGHT:   m_right = int'(v);
                default: ;
            endcase
        endfunction

        function void put_cell(int idx, logic [7:0] c);
            if (idx < 0 || idx >= CELLS) return;
            chars[idx] = reverse ? (c ^ REVERSE_MASK) : c;
            if (color_on) colors[idx] = pen_color;
        endfunction

        function void fill_blank(int idx, int n);
            for (int i = 0; i < n; i++) put_cell(idx + i, SPACE_CODE);
        endfunction

        function void move_cell(int dst, int src);
            if (dst >= CELLS || src >= CELLS) return;
            chars[dst] = chars[src];
            if (color_on) colors[dst] = colors[src];
        endfunction

        function void roll_up();
            for (int y = top; y < bot; y++)
                for (int x = left; x <= right; x++)
                    move_cell(y * cols + x, (y + 1) * cols + x);
            fill_blank(bot * cols + left, right - left + 1);
        endfunction

        function void roll_down();
            for (int y = bot; y > top; y--)
                for (int x = left; x <= right; x++)
                    move_cell(y * cols + x, (y - 1) * cols + x);
            fill_blank(top * cols + left, right - left + 1);
        endfunction

        function void line_feed();
            cur_row++;
            if (cur_row > bot) begin
                cur_row = bot;
                if (scroll_on) roll_up();
            end
        endfunction

        function void new_line();
            cur_col = left;
            wrap = 0;
            line_feed();
        endfunction

        function void step_back();
            wrap = 0;
            if (cur_col == left) begin
                cur_col = right;
                if (cur_row <= top) begin
                    cur_col = left;
                    cur_row = top;
                end else begin
                    cur_row--;
                end
            end else begin
                cur_col--;
            end
        endfunction

        function void put_char(logic [7:0] c);
            if (c == CH_CR) begin
                cur_col = left;
                wrap = 0;
            end else if (c == CH_LF) begin
                new_line();
            end else if (c == CH_BS) begin
                if (!wrap) step_back();
                wrap = 0;
                put_cell(cur_row * cols + cur_col, SPACE_CODE);
            end else if (c == CH_FF) begin
                cur_col = left;
                cur_row = top;
                wrap = 0;
                for (int y = top; y <= bot; y++) fill_blank(y * cols + left, right - left + 1);
            end else begin
                if (wrap) new_line();
                put_cell(cur_row * cols + cur_col, c);
                if (cur_col == right) begin
                    wrap = 1;
                end else begin
                    cur_col++;
                    if (cur_col > right) new_line();
                end
            end
        endfunction

        function int clamp_coord(logic [7:0] v, int hi);
            if (v[7]) return 0;
            return (int'(v) > hi) ? hi : int'(v);
        endfunction

        function void note_command(logic [39:0] d);
            tcw_cmd_t cmd;
            tcw_erase_t mode;
            int maxcol, idx, x, y;
            cursor_report_t r;
            cmd = tcw_cmd_t'(d[2:0]);
            mode = tcw_erase_t'(d[28:27]);
            pen_color = d[36:29];
            r = '0;
            cols = eighty ? WIDE : WIDE / 2;
            maxcol = cols - 1;
            top = m_top;
            bot = (m_bot > ROWS - 1) ? ROWS - 1 : m_bot;
            if (top >= bot) begin
                top = 0;
                bot = ROWS - 1;
            end
            left = m_left;
            right = (m_right > maxcol) ? maxcol : m_right;
            if (left >= right) begin
                left = 0;
                right = maxcol;
            end
            // A column below zero stands for a huge unsigned value and clamps the same way.
            if (cur_col < 0 || cur_col > maxcol) cur_col = maxcol;
            if (cur_row > ROWS - 1) cur_row = ROWS - 1;
            idx = cur_row * cols + cur_col;
            case (cmd)
                CMD_PUT: put_char(d[10:3]);
                CMD_GOTO: begin
                    cur_col = clamp_coord(d[18:11], maxcol);
                    cur_row = clamp_coord(d[26:19], ROWS - 1);
                    wrap = 0;
                end
                CMD_ERASE_S: begin
                    if (mode == ERASE_TO_END) fill_blank(idx, ROWS * cols - idx);
                    else if (mode == ERASE_FROM_BEG) fill_blank(0, idx + 1);
                    else if (mode == ERASE_ALL) fill_blank(0, ROWS * cols);
                end
                CMD_ERASE_L: begin
                    if (mode == ERASE_TO_END) fill_blank(idx, cols - cur_col);
                    else if (mode == ERASE_FROM_BEG) fill_blank(cur_row * cols, cur_col + 1);
                    else if (mode == ERASE_ALL) fill_blank(cur_row * cols, cols);
                end
                CMD_SCR_UP: roll_up();
                CMD_SCR_DN: roll_down();
                CMD_READ: begin
                    x = clamp_coord(d[18:11], maxcol);
                    y = clamp_coord(d[26:19], ROWS - 1);
                    idx = y * cols + x;
                    if (idx < CELLS) begin
                        r.rd_char = chars[idx];
                        r.rd_color = colors[idx];
                    end
                end
                default: ;
            endcase
            r.col = cur_col[6:0];
            r.row = cur_row[4:0];
            r.wrap = wrap;
            report_q.push_back(r);
        endfunction

        function void check_report(logic [31:0] m);
            cursor_report_t e, a;
            a = m[28:0];
            if (report_q.size() == 0) begin
                $error("unexpected result beat %h", m);
                errors++;
                return;
            end
            e = report_q.pop_front();
            if (a.col !== e.col) begin
                $error("cursor_col: expected %0d, got %0d", e.col, a.col); errors++;
            end
            if (a.row !== e.row) begin
                $error("cursor_row: expected %0d, got %0d", e.row, a.row); errors++;
            end
            if (a.wrap !== e.wrap) begin
                $error("wrap_pending: expected %0d, got %0d", e.wrap, a.wrap); errors++;
            end
            if (a.rd_char !== e.rd_char) begin
                $error("read_char: expected %h, got %h", e.rd_char, a.rd_char); errors++;
            end
            if (a.rd_color !== e.rd_color) begin
                $error("read_color: expected %h, got %h", e.rd_color, a.rd_color); errors++;
            end
        endfunction

        function int pending();
            return report_q.size();
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_addr = '0;
    logic [6:0]  cfg_data = '0;

    screen_scoreboard sb = new();
    int idle_mode = 0;
    int cycles = 0;

    text_console_cell_writer u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver stalls in idle modes 2 and 3.
    always @(negedge aclk) begin
        if (idle_mode == 2) m_tready <= ($urandom_range(0, 99) >= 88);
        else if (idle_mode == 3) m_tready <= ($urandom_range(0, 99) >= 17);
        else m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_report(m_tdata);
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic logic [1:0] rnd2();
        return 2'($urandom);
    endfunction

    function automatic bit sender_idle();
        if (idle_mode == 1) return $urandom_range(0, 99) < 88;
        if (idle_mode == 3) return $urandom_range(0, 99) < 17;
        return 0;
    endfunction

    task automatic send_cmd(tcw_cmd_t cmd, logic [7:0] ch, logic [7:0] col,
                            logic [7:0] row, logic [1:0] mode, logic [7:0] color);
        @(negedge aclk);
        while (sender_idle()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b0, color, mode, row, col, ch, cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_command({3'b0, color, mode, row, col, ch, cmd});
    endtask

    task automatic put(logic [7:0] ch);
        send_cmd(CMD_PUT, ch, rnd8(), rnd8(), rnd2(), rnd8());
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(tcw_cfg_t a, logic [6:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= a;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(a, v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_cmd();
        int pick;
        logic [7:0] ch;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            ch = rnd8();
            case ($urandom_range(0, 9))
                0: ch = CH_BS;
                1: ch = CH_LF;
                2: ch = CH_CR;
                default: if ($urandom_range(0, 30) == 0) ch = CH_FF;
            endcase
            put(ch);
        end else if (pick < 65) begin
            // Mostly land inside the wide screen, sometimes anywhere in the signed range.
            if ($urandom_range(0, 3) == 0)
                send_cmd(CMD_GOTO, rnd8(), rnd8(), rnd8(), rnd2(), rnd8());
            else
                send_cmd(CMD_GOTO, rnd8(), 8'($urandom_range(0, 79)),
                         8'($urandom_range(0, 24)), rnd2(), rnd8());
        end else if (pick < 75) begin
            send_cmd(CMD_READ, rnd8(), 8'($urandom_range(0, 79)),
                     8'($urandom_range(0, 24)), rnd2(), rnd8());
        end else if (pick < 78) begin
            send_cmd(CMD_ERASE_S, rnd8(), rnd8(), rnd8(), rnd2(), rnd8());
        end else if (pick < 85) begin
            send_cmd(CMD_ERASE_L, rnd8(), rnd8(), rnd8(), rnd2(), rnd8());
        end else if (pick < 89) begin
            send_cmd(CMD_SCR_UP, rnd8(), rnd8(), rnd8(), rnd2(), rnd8());
        end else if (pick < 93) begin
            send_cmd(CMD_SCR_DN, rnd8(), rnd8(), rnd8(), rnd2(), rnd8());
        end else if (pick < 95) begin
            send_cmd(CMD_NOP, rnd8(), rnd8(), rnd8(), rnd2(), rnd8());
        end else begin
            send_cmd(CMD_READ, rnd8(), rnd8(), rnd8(), rnd2(), rnd8());
        end
    endtask

    initial begin
        logic [6:0] setting [8];
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed pass at reset settings.
        send_cmd(CMD_GOTO, 8'h00, 8'h80, 8'h80, ERASE_TO_END, 8'h00);
        send_cmd(CMD_GOTO, 8'hFF, 8'h7F, 8'h7F, ERASE_NONE, 8'hFF);
        put(8'h41);
        put(8'hFF);
        put(8'h00);
        send_cmd(CMD_GOTO, 8'h00, 8'd38, 8'd24, ERASE_TO_END, 8'h00);
        put(8'h42);
        put(8'h43);
        put(8'h44);
        put(CH_BS);
        put(CH_CR);
        put(CH_LF);
        put(CH_BS);
        send_cmd(CMD_READ, 8'h00, 8'd0, 8'd23, ERASE_TO_END, 8'h00);
        send_cmd(CMD_READ, 8'h00, 8'hFF, 8'h7F, ERASE_TO_END, 8'h00);
        for (int m = 0; m < 4; m++)
            send_cmd(CMD_ERASE_L, 8'h00, 8'd0, 8'd0, tcw_erase_t'(m), 8'h5A);
        send_cmd(CMD_ERASE_S, 8'h00, 8'd0, 8'd0, ERASE_NONE, 8'h00);
        send_cmd(CMD_ERASE_S, 8'h00, 8'd0, 8'd0, ERASE_TO_END, 8'h00);
        send_cmd(CMD_SCR_UP, 8'h00, 8'd0, 8'd0, ERASE_TO_END, 8'h00);
        send_cmd(CMD_SCR_DN, 8'h00, 8'd0, 8'd0, ERASE_TO_END, 8'h00);
        send_cmd(CMD_NOP, 8'h00, 8'd0, 8'd0, ERASE_TO_END, 8'h00);
        put(CH_FF);
        repeat (40) random_cmd();
        wait_idle();

        for (int phase = 1; phase <= 6; phase++) begin
            case (phase)
                1: setting = '{7'd1, 7'd1, 7'd0, 7'd1, 7'd2, 7'd20, 7'd5, 7'd70};
                2: setting = '{7'd1, 7'd1, 7'd1, 7'd0, 7'd0, 7'd24, 7'd0, 7'd79};
                3: setting = '{7'd0, 7'd1, 7'd1, 7'd1, 7'd24, 7'd0, 7'd79, 7'd0};
                4: setting = '{7'd0, 7'd0, 7'd0, 7'd1, 7'd10, 7'd24, 7'd10, 7'd79};
                5: setting = '{7'd1, 7'd0, 7'd1, 7'd1, 7'd12, 7'd13, 7'd78, 7'd79};
                default: setting = '{7'($urandom_range(0, 1)), 7'($urandom_range(0, 1)),
                                     7'($urandom_range(0, 1)), 7'($urandom_range(0, 1)),
                                     7'($urandom_range(0, 24)), 7'($urandom_range(0, 24)),
                                     7'($urandom_range(0, 79)), 7'($urandom_range(0, 79))};
            endcase
            idle_mode = phase % 4;
            for (int r = 0; r < 8; r++) write_reg(tcw_cfg_t'(r), setting[r]);
            repeat (45) random_cmd();
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
